// ===== rtl/core/sepblur_pkg.sv =====
// Shared constants, item type and kernel function of the separable seven-tap blur.
package sepblur_pkg;

	localparam int MaxWidth  = 8192;
	localparam int Taps      = 7;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int CfgWidthW = 14;
	localparam int CfgHeightW = 16;
	localparam int WinW      = 8 * (Taps - 1);
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);

	localparam logic [0:0] RegWidth  = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;

	localparam logic [15:0] KernEdge  = 16'd2;
	localparam logic [15:0] KernOuter = 16'd15;
	localparam logic [15:0] KernInner = 16'd62;
	localparam logic [15:0] KernMid   = 16'd98;

	typedef struct packed {
		logic has_col;
		logic emit;
		logic row_end;
		logic frame_end;
	} item_flags_t;

	typedef struct packed {
		logic [7:0]      pixel;
		logic [WinW-1:0] window;
		logic [ColW-1:0] col;
		item_flags_t     flags;
	} item_t;

	// Six packed bytes, byte 0 the oldest, and the newest byte through the kernel.
	function automatic logic [7:0] fir7(input logic [WinW-1:0] six, input logic [7:0] newest);
		logic [15:0] sum;
		sum = KernEdge  * {8'd0, six[7:0]}
		    + KernOuter * {8'd0, six[15:8]}
		    + KernInner * {8'd0, six[23:16]}
		    + KernMid   * {8'd0, six[31:24]}
		    + KernInner * {8'd0, six[39:32]}
		    + KernOuter * {8'd0, six[47:40]}
		    + KernEdge  * {8'd0, newest};
		return sum[15:8];
	endfunction

endpackage

// ===== rtl/core/sepblur_front.sv =====
// Front end: accepts pixels, tracks column and row, keeps the row window, classifies items.
module sepblur_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic [7:0]                          pixel_in,
	input  logic [sepblur_pkg::CfgWidthW-1:0]   image_width,
	input  logic [sepblur_pkg::CfgHeightW-1:0]  image_height,
	input  logic                                restart,
	input  logic                                q_full,
	output logic                                q_push,
	output sepblur_pkg::item_t                  q_item
);

	logic [sepblur_pkg::ColW-1:0]       col_q;
	logic [sepblur_pkg::CfgHeightW-1:0] row_q;
	logic [sepblur_pkg::WinW-1:0]       window_q;
	logic [sepblur_pkg::ColW-1:0]       col_last;
	logic [sepblur_pkg::CfgHeightW-1:0] row_last;
	logic                               at_row_end;
	logic                               at_frame_end;

	// Widths and heights below the kernel act as the kernel length; widths above the line store clamp.
	always_comb begin
		priority if (image_width < sepblur_pkg::CfgWidthW'(sepblur_pkg::Taps)) begin
			col_last = sepblur_pkg::ColW'(sepblur_pkg::Taps - 1);
		end else if (image_width > sepblur_pkg::CfgWidthW'(sepblur_pkg::MaxWidth)) begin
			col_last = sepblur_pkg::ColW'(sepblur_pkg::MaxWidth - 1);
		end else begin
			col_last = sepblur_pkg::ColW'(image_width - sepblur_pkg::CfgWidthW'(1));
		end
		if (image_height < sepblur_pkg::CfgHeightW'(sepblur_pkg::Taps)) begin
			row_last = sepblur_pkg::CfgHeightW'(sepblur_pkg::Taps - 1);
		end else begin
			row_last = image_height - sepblur_pkg::CfgHeightW'(1);
		end
	end

	assign pix_stall    = q_full;
	assign q_push       = pix_valid && !q_full;
	assign at_row_end   = (col_q == col_last);
	assign at_frame_end = at_row_end && (row_q == row_last);

	always_comb begin
		q_item.pixel           = pixel_in;
		q_item.window          = window_q;
		q_item.col             = col_q - sepblur_pkg::ColW'(sepblur_pkg::Taps - 1);
		q_item.flags.has_col   = (col_q >= sepblur_pkg::ColW'(sepblur_pkg::Taps - 1));
		q_item.flags.emit      = q_item.flags.has_col
		                         && (row_q >= sepblur_pkg::CfgHeightW'(sepblur_pkg::Taps - 1));
		q_item.flags.row_end   = at_row_end;
		q_item.flags.frame_end = at_frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			window_q <= '0;
		end else if (restart) begin
			col_q    <= '0;
			row_q    <= '0;
			window_q <= '0;
		end else if (q_push) begin
			window_q <= {pixel_in, window_q[sepblur_pkg::WinW-1:8]};
			if (at_row_end) begin
				col_q <= '0;
				row_q <= at_frame_end ? '0 : row_q + sepblur_pkg::CfgHeightW'(1);
			end else begin
				col_q <= col_q + sepblur_pkg::ColW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/sepblur_fifo.sv =====
// Short item queue between the front end and the filter back end.
module sepblur_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sepblur_pkg::item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output sepblur_pkg::item_t pop_item
);

	sepblur_pkg::item_t                   slots_q [sepblur_pkg::FifoDepth];
	logic [sepblur_pkg::FifoPtrW-1:0]     wr_ptr_q;
	logic [sepblur_pkg::FifoPtrW-1:0]     rd_ptr_q;
	logic [sepblur_pkg::FifoPtrW:0]       count_q;

	assign full     = (count_q == (sepblur_pkg::FifoPtrW + 1)'(sepblur_pkg::FifoDepth));
	assign empty    = (count_q == '0);
	assign pop_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sepblur_pkg::FifoPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sepblur_pkg::FifoPtrW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (sepblur_pkg::FifoPtrW + 1)'(1);
				2'b01:   count_q <= count_q - (sepblur_pkg::FifoPtrW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/sepblur_back.sv =====
// Back end: horizontal filter, line store update, vertical filter and output register.
module sepblur_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  sepblur_pkg::item_t q_item,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [7:0]         pixel_out,
	output logic               row_end,
	output logic               frame_end
);

	logic [sepblur_pkg::WinW-1:0] line_mem [sepblur_pkg::MaxWidth];

	logic                         advance;
	logic                         v_s1;
	sepblur_pkg::item_t           item_s1;
	logic [sepblur_pkg::WinW-1:0] col_rd_s1;
	logic [7:0]                   hv_s1;
	logic                         line_wr;

	logic                         v_s2;
	logic [sepblur_pkg::WinW-1:0] col_s2;
	logic [7:0]                   hv_s2;
	logic                         row_end_s2;
	logic                         frame_end_s2;

	logic                         valid_q;
	logic [7:0]                   pixel_q;
	logic                         row_end_q;
	logic                         frame_end_q;

	// The whole pipeline moves together whenever the output register can take a result.
	assign advance = !valid_q || !res_stall;
	assign q_pop   = advance && !q_empty;
	assign hv_s1   = sepblur_pkg::fir7(item_s1.window, item_s1.pixel);
	assign line_wr = advance && v_s1 && item_s1.flags.has_col;

	// The same column comes back only every width items, so the read at pop time
	// never overlaps the write of the item one stage ahead.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_rd_s1 <= line_mem[q_item.col];
		end
	end

	always_ff @(posedge clk) begin
		if (line_wr) begin
			line_mem[item_s1.col] <= {hv_s1, col_rd_s1[sepblur_pkg::WinW-1:8]};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1      <= q_item;
			col_s2       <= col_rd_s1;
			hv_s2        <= hv_s1;
			row_end_s2   <= item_s1.flags.row_end;
			frame_end_s2 <= item_s1.flags.frame_end;
			pixel_q      <= sepblur_pkg::fir7(col_s2, hv_s2);
			row_end_q    <= row_end_s2;
			frame_end_q  <= frame_end_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= q_pop;
			v_s2    <= v_s1 && item_s1.flags.emit;
			valid_q <= v_s2;
		end
	end

	assign res_valid = valid_q;
	assign pixel_out = pixel_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule

// ===== rtl/core/separable_seven_tap_blur.sv =====
// Top level of the separable seven-tap blur: register port, front end, queue and back end.
// Throughput is one pixel per clock unless results stall; the line store takes one read and one
// write per cycle. An accepted pixel passes the queue, stages s1 and s2 and the output register.
// Reset clears the counters, row window, queue and pipeline valids; the registers return to
// width 6000 and height 4500. The line store has no reset and needs no clearing pass.
module separable_seven_tap_blur (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [7:0]  pixel_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  pixel_out,
	output logic        row_end,
	output logic        frame_end
);

	logic [sepblur_pkg::CfgWidthW-1:0]  image_width_q;
	logic [sepblur_pkg::CfgHeightW-1:0] image_height_q;
	logic                               cfg_write;
	logic [0:0]                         reg_index;

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	sepblur_pkg::item_t push_item;
	sepblur_pkg::item_t pop_item;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_index = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= sepblur_pkg::CfgWidthW'(6000);
			image_height_q <= sepblur_pkg::CfgHeightW'(4500);
		end else if (cfg_write) begin
			unique case (reg_index)
				sepblur_pkg::RegWidth:  image_width_q  <= pwdata[sepblur_pkg::CfgWidthW-1:0];
				sepblur_pkg::RegHeight: image_height_q <= pwdata[sepblur_pkg::CfgHeightW-1:0];
				default:                image_width_q  <= image_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			sepblur_pkg::RegWidth:  prdata = {{(32 - sepblur_pkg::CfgWidthW){1'b0}}, image_width_q};
			sepblur_pkg::RegHeight: prdata = {{(32 - sepblur_pkg::CfgHeightW){1'b0}}, image_height_q};
			default:                prdata = '0;
		endcase
	end

	sepblur_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pixel_in     (pixel_in),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.restart      (cfg_write),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (push_item)
	);

	sepblur_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	sepblur_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.pixel_out (pixel_out),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

	// A frame can only end on the last pixel of an output row.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!frame_end || row_end))
	else $error("frame_end without row_end");

	// A push by the front end leaves the queue holding at least one item.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
	else $error("pushed item missing from queue");

	// The back end never pops while the output register is stalled with a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !q_pop)
	else $error("queue popped while output stalled");

endmodule
